[rtl/tszs_pkg.sv]
`default_nettype none
package tszs_pkg;

  localparam int unsigned MaxElements = 256;
  localparam int unsigned ValueWidth  = 32;
  localparam int unsigned InWidth     = 32;
  localparam int unsigned PosOutWidth = 8;
  localparam int unsigned MinSet      = 3;

  typedef struct packed {
    logic ins;
    logic shift;
  } chain_ctrl_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DRAIN,
    ST_ANCH,
    ST_TGT,
    ST_RD,
    ST_CMP,
    ST_DONE
  } state_e;

endpackage
`default_nettype wire

[rtl/tszs_cell.sv]
`default_nettype none
module tszs_cell
  import tszs_pkg::*;
#(
  parameter int unsigned VW = ValueWidth,
  parameter int unsigned PW = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire chain_ctrl_t          ctrl_i,
  input  wire logic signed [VW-1:0] key_val_i,
  input  wire logic [PW-1:0]        key_pos_i,
  input  wire logic                 prev_gt_i,
  input  wire logic                 prev_valid_i,
  input  wire logic signed [VW-1:0] prev_val_i,
  input  wire logic [PW-1:0]        prev_pos_i,
  input  wire logic                 next_valid_i,
  input  wire logic signed [VW-1:0] next_val_i,
  input  wire logic [PW-1:0]        next_pos_i,
  output logic                      gt_o,
  output logic                      valid_o,
  output logic signed [VW-1:0]      val_o,
  output logic [PW-1:0]             pos_o
);

  logic                 valid_q;
  logic signed [VW-1:0] val_q;
  logic [PW-1:0]        pos_q;

  assign gt_o    = !valid_q || (key_val_i < val_q);
  assign valid_o = valid_q;
  assign val_o   = val_q;
  assign pos_o   = pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      valid_q <= next_valid_i;
    end else if (ctrl_i.ins && gt_o) begin
      valid_q <= !prev_gt_i || prev_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      val_q <= next_val_i;
      pos_q <= next_pos_i;
    end else if (ctrl_i.ins && gt_o) begin
      if (prev_gt_i) begin
        val_q <= prev_val_i;
        pos_q <= prev_pos_i;
      end else begin
        val_q <= key_val_i;
        pos_q <= key_pos_i;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/tszs_chain.sv]
`default_nettype none
module tszs_chain
  import tszs_pkg::*;
#(
  parameter int unsigned N  = MaxElements,
  parameter int unsigned VW = ValueWidth,
  parameter int unsigned PW = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire chain_ctrl_t          ctrl_i,
  input  wire logic signed [VW-1:0] key_val_i,
  input  wire logic [PW-1:0]        key_pos_i,
  output logic signed [VW-1:0]      head_val_o,
  output logic [PW-1:0]             head_pos_o
);

  logic                 gt    [N];
  logic                 valid [N];
  logic signed [VW-1:0] val   [N];
  logic [PW-1:0]        pos   [N];

  for (genvar j = 0; j < N; j++) begin : g_cell
    logic                 p_gt;
    logic                 p_valid;
    logic signed [VW-1:0] p_val;
    logic [PW-1:0]        p_pos;
    logic                 n_valid;
    logic signed [VW-1:0] n_val;
    logic [PW-1:0]        n_pos;

    if (j == 0) begin : g_first
      assign p_gt    = 1'b0;
      assign p_valid = 1'b1;
      assign p_val   = key_val_i;
      assign p_pos   = key_pos_i;
    end else begin : g_mid
      assign p_gt    = gt[j-1];
      assign p_valid = valid[j-1];
      assign p_val   = val[j-1];
      assign p_pos   = pos[j-1];
    end

    if (j == N - 1) begin : g_end
      assign n_valid = 1'b0;
      assign n_val   = key_val_i;
      assign n_pos   = key_pos_i;
    end else begin : g_inner
      assign n_valid = valid[j+1];
      assign n_val   = val[j+1];
      assign n_pos   = pos[j+1];
    end

    tszs_cell #(.VW(VW), .PW(PW)) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .key_val_i   (key_val_i),
      .key_pos_i   (key_pos_i),
      .prev_gt_i   (p_gt),
      .prev_valid_i(p_valid),
      .prev_val_i  (p_val),
      .prev_pos_i  (p_pos),
      .next_valid_i(n_valid),
      .next_val_i  (n_val),
      .next_pos_i  (n_pos),
      .gt_o        (gt[j]),
      .valid_o     (valid[j]),
      .val_o       (val[j]),
      .pos_o       (pos[j])
    );
  end

  assign head_val_o = val[0];
  assign head_pos_o = pos[0];

endmodule
`default_nettype wire

[rtl/tszs_search.sv]
`default_nettype none
module tszs_search
  import tszs_pkg::*;
#(
  parameter int unsigned N  = MaxElements,
  parameter int unsigned VW = ValueWidth,
  parameter int unsigned PW = 8,
  parameter int unsigned CW = 9
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 last_i,
  output logic                      in_stall_o,
  output chain_ctrl_t               ctrl_o,
  output logic [PW-1:0]             key_pos_o,
  input  wire logic signed [VW-1:0] head_val_i,
  input  wire logic [PW-1:0]        head_pos_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic                      found_o,
  output logic [PosOutWidth-1:0]    first_pos_o,
  output logic [PosOutWidth-1:0]    second_pos_o,
  output logic [PosOutWidth-1:0]    third_pos_o
);

  localparam int unsigned MW = VW + PW;
  localparam int unsigned SW = VW + 2;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, wr_q, wr_d;
  logic [PW-1:0] i_q, i_d, l_q, l_d, r_q, r_d;
  logic signed [VW-1:0] iv_q, iv_d;
  logic [PW-1:0] ip_q, ip_d;
  logic res_f_q, res_f_d;
  logic [PW-1:0] res_a_q, res_a_d, res_b_q, res_b_d, res_c_q, res_c_d;
  logic out_v_q, out_v_d, out_ld;
  logic [PW-1:0] addr_a, addr_b;

  logic [MW-1:0] mem [N];
  logic [MW-1:0] rd_a_q, rd_b_q;
  logic mem_we;

  logic signed [VW-1:0] a_val, b_val;
  logic [PW-1:0] a_pos, b_pos;
  logic signed [SW-1:0] tsum;
  logic [PW-1:0] s0, s1, s2, t0, t1;
  logic accept;
  logic [CW-1:0] cnt_m1;

  assign a_val = rd_a_q[MW-1:PW];
  assign a_pos = rd_a_q[PW-1:0];
  assign b_val = rd_b_q[MW-1:PW];
  assign b_pos = rd_b_q[PW-1:0];
  assign tsum  = SW'(a_val) + SW'(b_val) + SW'(iv_q);
  assign cnt_m1 = cnt_q - CW'(1);
  assign key_pos_o = cnt_q[PW-1:0];

  always_comb begin
    t0 = (ip_q < a_pos) ? ip_q : a_pos;
    t1 = (ip_q < a_pos) ? a_pos : ip_q;
    s2 = (t1 < b_pos) ? b_pos : t1;
    s1 = (t1 < b_pos) ? t1 : b_pos;
    s0 = (t0 < s1) ? t0 : s1;
    if (t0 >= s1) s1 = t0;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_q[PW-1:0]] <= {head_val_i, head_pos_i};
    rd_a_q <= mem[addr_a];
    rd_b_q <= mem[addr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_q    <= wr_d;
    i_q     <= i_d;
    l_q     <= l_d;
    r_q     <= r_d;
    iv_q    <= iv_d;
    ip_q    <= ip_d;
    res_f_q <= res_f_d;
    res_a_q <= res_a_d;
    res_b_q <= res_b_d;
    res_c_q <= res_c_d;
    if (out_ld) begin
      found_o      <= res_f_q;
      first_pos_o  <= res_f_q ? PosOutWidth'(res_a_q) : '0;
      second_pos_o <= res_f_q ? PosOutWidth'(res_b_q) : '0;
      third_pos_o  <= res_f_q ? PosOutWidth'(res_c_q) : '0;
    end
  end

  assign out_valid_o = out_v_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    wr_d = wr_q;
    i_d = i_q;
    l_d = l_q;
    r_d = r_q;
    iv_d = iv_q;
    ip_d = ip_q;
    res_f_d = res_f_q;
    res_a_d = res_a_q;
    res_b_d = res_b_q;
    res_c_d = res_c_q;
    out_v_d = out_v_q && out_stall_i;
    out_ld = 1'b0;
    in_stall_o = 1'b1;
    ctrl_o = '0;
    mem_we = 1'b0;
    addr_a = l_q;
    addr_b = r_q;
    accept = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        accept = in_valid_i;
        if (accept && (cnt_q < CW'(N))) begin
          ctrl_o.ins = 1'b1;
          cnt_d = cnt_q + CW'(1);
        end
        if (accept && last_i) begin
          state_d = ST_DRAIN;
          wr_d = '0;
        end
      end
      ST_DRAIN: begin
        ctrl_o.shift = 1'b1;
        mem_we = 1'b1;
        wr_d = wr_q + CW'(1);
        if (wr_q == cnt_m1) begin
          i_d = '0;
          if (cnt_q < CW'(MinSet)) begin
            res_f_d = 1'b0;
            state_d = ST_DONE;
          end else begin
            state_d = ST_ANCH;
          end
        end
      end
      ST_ANCH: begin
        addr_a = i_q;
        state_d = ST_TGT;
      end
      ST_TGT: begin
        iv_d = a_val;
        ip_d = a_pos;
        l_d = i_q + PW'(1);
        r_d = cnt_m1[PW-1:0];
        state_d = ST_RD;
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (tsum == '0) begin
          res_f_d = 1'b1;
          res_a_d = s0;
          res_b_d = s1;
          res_c_d = s2;
          state_d = ST_DONE;
        end else begin
          if (tsum < 0) l_d = l_q + PW'(1);
          else          r_d = r_q - PW'(1);
          if (l_d < r_d) begin
            state_d = ST_RD;
          end else if (CW'(i_q) + CW'(MinSet) < cnt_q) begin
            i_d = i_q + PW'(1);
            state_d = ST_ANCH;
          end else begin
            res_f_d = 1'b0;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_v_q || !out_stall_i) begin
          out_ld = 1'b1;
          out_v_d = 1'b1;
          cnt_d = '0;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

endmodule
`default_nettype wire

[rtl/three_sum_zero_search.sv]
// Zero-sum triple search over a streamed set of signed values.
// Input channel: value_i / last_i beats with in_valid_i, held off by
// in_stall_o. One element is taken per cycle while a set loads; each is
// inserted in sorted place into a row of compare-and-shift cells. The
// beat with last_i closes the set. After that the input stalls while the
// cell row drains into the sorted memory, then the two-pointer search
// runs: each anchor is set up in ST_ANCH and ST_TGT, and each pointer
// step is one registered memory read (ST_RD) and one compare (ST_CMP).
// Output channel: one result beat per set (found_o and three positions),
// with out_valid_o, held while out_stall_i is high. The result sits in
// an output register, so the next set may load while it waits.
// Elements past MAX_ELEMENTS are dropped; their last mark still closes.
// Reset clears the set and leaves the output empty.
`default_nettype none
module three_sum_zero_search
  import tszs_pkg::*;
#(
  parameter int unsigned MAX_ELEMENTS = MaxElements,
  parameter int unsigned VALUE_WIDTH  = ValueWidth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic signed [InWidth-1:0] value_i,
  input  wire logic                   last_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic                        found_o,
  output logic [PosOutWidth-1:0]      first_pos_o,
  output logic [PosOutWidth-1:0]      second_pos_o,
  output logic [PosOutWidth-1:0]      third_pos_o
);

  localparam int unsigned PW = $clog2(MAX_ELEMENTS);
  localparam int unsigned CW = $clog2(MAX_ELEMENTS + 1);

  logic signed [VALUE_WIDTH-1:0] key_val, head_val;
  logic [PW-1:0] key_pos, head_pos;
  chain_ctrl_t ctrl;

  if (VALUE_WIDTH <= InWidth) begin : g_narrow
    assign key_val = value_i[VALUE_WIDTH-1:0];
  end else begin : g_wide
    assign key_val = {{(VALUE_WIDTH - InWidth){1'b0}}, value_i};
  end

  tszs_chain #(.N(MAX_ELEMENTS), .VW(VALUE_WIDTH), .PW(PW)) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .key_val_i (key_val),
    .key_pos_i (key_pos),
    .head_val_o(head_val),
    .head_pos_o(head_pos)
  );

  tszs_search #(.N(MAX_ELEMENTS), .VW(VALUE_WIDTH), .PW(PW), .CW(CW)) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_i      (last_i),
    .in_stall_o  (in_stall_o),
    .ctrl_o      (ctrl),
    .key_pos_o   (key_pos),
    .head_val_i  (head_val),
    .head_pos_i  (head_pos),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .found_o     (found_o),
    .first_pos_o (first_pos_o),
    .second_pos_o(second_pos_o),
    .third_pos_o (third_pos_o)
  );

endmodule
`default_nettype wire

[rtl/tszs_checker.sv]
`default_nettype none
module tszs_checker
  import tszs_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   in_valid_i,
  input wire logic                   in_stall_o,
  input wire logic                   last_i,
  input wire logic                   out_valid_o,
  input wire logic                   out_stall_i,
  input wire logic                   found_o,
  input wire logic [PosOutWidth-1:0] first_pos_o,
  input wire logic [PosOutWidth-1:0] second_pos_o,
  input wire logic [PosOutWidth-1:0] third_pos_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o)
      && $stable(first_pos_o) && $stable(second_pos_o) && $stable(third_pos_o))
    else $error("result beat changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> first_pos_o == '0 && second_pos_o == '0
      && third_pos_o == '0)
    else $error("not-found result carries positions");

  a_close_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && last_i |=> in_stall_o)
    else $error("input taken right after set closed");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while loading");

endmodule

bind three_sum_zero_search tszs_checker u_tszs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .found_o     (found_o),
  .first_pos_o (first_pos_o),
  .second_pos_o(second_pos_o),
  .third_pos_o (third_pos_o)
);
`default_nettype wire
